### sv/csvs_pkg.sv
// shared types, codes and constants of the csv record field splitter
package csvs_pkg;

	// record and column limits
	localparam int unsigned MAX_RECORD_BYTES = 4096;
	localparam int unsigned COLUMN_LIMIT_MAX = 64;

	// field widths
	localparam int unsigned POS_W  = 13;
	localparam int unsigned OFF_W  = 12;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned EV_W   = 3;
	localparam int unsigned ERR_W  = 2;
	localparam int unsigned BYTE_W = 8;

	// result item tdata layout, padded to whole bytes
	localparam int unsigned RES_DATA_W = 40;

	// event codes
	localparam logic [EV_W-1:0] EV_PLAIN  = 3'd0;
	localparam logic [EV_W-1:0] EV_SEP    = 3'd1;
	localparam logic [EV_W-1:0] EV_RECORD = 3'd2;
	localparam logic [EV_W-1:0] EV_STREAM = 3'd3;
	localparam logic [EV_W-1:0] EV_ERROR  = 3'd4;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
	localparam logic [ERR_W-1:0] ERR_TOO_LONG   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_COLUMNS    = 2'd2;
	localparam logic [ERR_W-1:0] ERR_QUOTED_END = 2'd3;

	// register indexes on the configuration port
	localparam logic REG_SEPARATOR_CHAR = 1'b0;
	localparam logic REG_COLUMN_LIMIT   = 1'b1;

	// register reset values
	localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd44;
	localparam logic [CNT_W-1:0]  MAX_SEP_RESET   = 7'd64;

	// special bytes
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	// parser state
	typedef struct packed {
		logic              in_quotes;
		logic [POS_W-1:0]  record_position;
		logic [CNT_W-1:0]  separator_count;
		logic              previous_was_cr;
		logic              stream_finished;
		logic [ERR_W-1:0]  sticky_error;
	} state_t;

	// configuration seen by the parser
	typedef struct packed {
		logic [BYTE_W-1:0] separator_char;
		logic [CNT_W-1:0]  column_limit;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [EV_W-1:0]   event_res;
		logic [OFF_W-1:0]  byte_offset;
		logic [CNT_W-1:0]  field_index;
		logic [POS_W-1:0]  content_end;
		logic [ERR_W-1:0]  error_code;
	} result_t;

endpackage

### sv/csvs_step.sv
// next-state and result logic for one csv byte or end-of-input item
module csvs_step (
	input  csvs_pkg::state_t             st,
	input  csvs_pkg::cfg_t               cfg,
	input  logic [csvs_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         end_of_input,
	output csvs_pkg::state_t             st_next,
	output csvs_pkg::result_t            res
);

	logic [csvs_pkg::CNT_W-1:0] limit;
	logic [csvs_pkg::POS_W-1:0] pos_inc;
	logic                       is_sep;

	// column limit capped at the build maximum
	assign limit = (cfg.column_limit > csvs_pkg::CNT_W'(csvs_pkg::COLUMN_LIMIT_MAX)) ?
		csvs_pkg::CNT_W'(csvs_pkg::COLUMN_LIMIT_MAX) : cfg.column_limit;
	assign pos_inc = st.record_position + csvs_pkg::POS_W'(1);
	assign is_sep  = (data_byte == cfg.separator_char);

	// decision tree for one item
	always_comb begin
		st_next         = st;
		res.event_res   = csvs_pkg::EV_PLAIN;
		res.byte_offset = st.record_position[csvs_pkg::OFF_W-1:0];
		res.field_index = st.separator_count;
		res.content_end = '0;
		res.error_code  = csvs_pkg::ERR_NONE;
		if (st.sticky_error != csvs_pkg::ERR_NONE) begin
			// sticky error repeats and changes nothing
			res.event_res  = csvs_pkg::EV_ERROR;
			res.error_code = st.sticky_error;
		end else if (st.stream_finished) begin
			res.event_res   = csvs_pkg::EV_STREAM;
			res.byte_offset = '0;
			res.field_index = '0;
		end else if (end_of_input) begin
			if (st.in_quotes) begin
				res.event_res        = csvs_pkg::EV_ERROR;
				res.error_code       = csvs_pkg::ERR_QUOTED_END;
				st_next.sticky_error = csvs_pkg::ERR_QUOTED_END;
			end else begin
				st_next.stream_finished = 1'b1;
				if (st.record_position != '0) begin
					// close the open record untrimmed
					res.event_res           = csvs_pkg::EV_RECORD;
					res.content_end         = st.record_position;
					st_next.record_position = '0;
					st_next.separator_count = '0;
					st_next.previous_was_cr = 1'b0;
				end else begin
					res.event_res   = csvs_pkg::EV_STREAM;
					res.byte_offset = '0;
					res.field_index = '0;
				end
			end
		end else if (st.record_position >= csvs_pkg::POS_W'(csvs_pkg::MAX_RECORD_BYTES)) begin
			res.event_res        = csvs_pkg::EV_ERROR;
			res.error_code       = csvs_pkg::ERR_TOO_LONG;
			st_next.sticky_error = csvs_pkg::ERR_TOO_LONG;
		end else if (!st.in_quotes && is_sep) begin
			if (st.separator_count >= limit) begin
				res.event_res        = csvs_pkg::EV_ERROR;
				res.error_code       = csvs_pkg::ERR_COLUMNS;
				st_next.sticky_error = csvs_pkg::ERR_COLUMNS;
			end else begin
				res.event_res           = csvs_pkg::EV_SEP;
				st_next.separator_count = st.separator_count + csvs_pkg::CNT_W'(1);
				st_next.record_position = pos_inc;
				st_next.previous_was_cr = 1'b0;
			end
		end else if (!st.in_quotes && (data_byte == csvs_pkg::CH_LF)) begin
			// record end, trimming one trailing cr
			res.event_res = csvs_pkg::EV_RECORD;
			if (st.previous_was_cr && (st.record_position != '0)) begin
				res.content_end = st.record_position - csvs_pkg::POS_W'(1);
			end else begin
				res.content_end = st.record_position;
			end
			st_next.record_position = '0;
			st_next.separator_count = '0;
			st_next.previous_was_cr = 1'b0;
		end else begin
			// plain byte; a quote toggles the quoted state
			if (data_byte == csvs_pkg::CH_QUOTE) begin
				st_next.in_quotes = !st.in_quotes;
			end
			st_next.record_position = pos_inc;
			st_next.previous_was_cr = (data_byte == csvs_pkg::CH_CR);
		end
	end

endmodule

### sv/csv_record_field_splitter_unit.sv
// top level of the csv record field splitter: stream ports, registers, output stage
// The splitter takes one CSV byte (or an end-of-input marker in tuser) per
// cycle and returns exactly one result item per input item from an output
// register; the parser state advances in the same cycle the item is
// accepted, so a new item can enter every cycle as long as the output
// register is empty or being drained. Each result gives the event kind in
// tuser and byte offset, field index, content end and error code in tdata.
// Errors are sticky until reset. The separator byte and column limit (APB 0, 4)
// must be set by the user only while the stream is idle (the block does not enforce it).
module csv_record_field_splitter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,   // data_byte
	input  logic                               s_axis_tuser,   // end_of_input
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// byte_offset, field_index, content_end, error_code, zero pad
	output logic [csvs_pkg::RES_DATA_W-1:0]    m_axis_tdata,
	output logic [csvs_pkg::EV_W-1:0]          m_axis_tuser,   // event_res
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	csvs_pkg::cfg_t    cfg_q;
	csvs_pkg::state_t  state_q;
	csvs_pkg::state_t  state_next;
	csvs_pkg::result_t res;
	csvs_pkg::result_t res_q;
	logic              out_valid_q;
	logic              in_fire;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.separator_char <= csvs_pkg::SEPARATOR_RESET;
			cfg_q.column_limit   <= csvs_pkg::MAX_SEP_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				csvs_pkg::REG_SEPARATOR_CHAR: cfg_q.separator_char <= pwdata[7:0];
				csvs_pkg::REG_COLUMN_LIMIT:   cfg_q.column_limit   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[2])
			csvs_pkg::REG_SEPARATOR_CHAR: prdata = {24'd0, cfg_q.separator_char};
			csvs_pkg::REG_COLUMN_LIMIT:   prdata = {25'd0, cfg_q.column_limit};
			default:                      prdata = '0;
		endcase
	end

	// parser logic
	csvs_step u_step (
		.st           (state_q),
		.cfg          (cfg_q),
		.data_byte    (s_axis_tdata),
		.end_of_input (s_axis_tuser),
		.st_next      (state_next),
		.res          (res)
	);

	// accept while the output register is free or draining
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.event_res;
	assign m_axis_tdata  = {6'd0, res_q.error_code, res_q.content_end,
		res_q.field_index, res_q.byte_offset};

endmodule

### sv/csvs_checker.sv
// port-level checks for the csv record field splitter, bound to the top level
module csvs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [csvs_pkg::RES_DATA_W-1:0] m_axis_tdata,
	input logic [csvs_pkg::EV_W-1:0]       m_axis_tuser
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result item changed");

	// an empty output stage never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// error code is set exactly on error events
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		((m_axis_tuser == csvs_pkg::EV_ERROR) == (m_axis_tdata[33:32] != csvs_pkg::ERR_NONE)))
		else $error("error code and event kind disagree");

	// content end only on record end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != csvs_pkg::EV_RECORD) |-> (m_axis_tdata[31:19] == '0))
		else $error("content end outside a record end");

	// a sticky error repeats on the next item that follows directly
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && (m_axis_tuser == csvs_pkg::EV_ERROR) &&
		s_axis_tvalid |=> m_axis_tvalid && (m_axis_tuser == csvs_pkg::EV_ERROR))
		else $error("error did not stick");

endmodule

bind csv_record_field_splitter_unit csvs_checker u_csvs_checker (.*);

### tb/sv/tb.sv
// testbench for the csv record field splitter: stream driver, result checker, field predictor
`timescale 1ns / 1ps

module tb;
	import csvs_pkg::*;

	// one input item: a text byte or an end-of-input marker
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_input;
	} csv_in_t;

	// ways the run may close its stream
	typedef enum int {
		END_EOI_EMPTY,
		END_EOI_RECORD,
		END_EOI_QUOTED,
		END_COLUMNS
	} ending_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;   // data_byte
	logic                  s_axis_tuser  = 1'b0; // end_of_input
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// byte_offset, field_index, content_end, error_code, zero pad
	logic [RES_DATA_W-1:0] m_axis_tdata;
	logic [EV_W-1:0]       m_axis_tuser;         // event_res
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [2:0]            paddr   = '0;
	logic [31:0]           pwdata  = '0;
	logic [31:0]           prdata;
	logic                  pready;

	csv_in_t pending_bytes[$];
	result_t expected_results[$];

	cfg_t    cfg;
	state_t  gen_st;      // parser state seen by the stimulus generator
	state_t  split_st;    // parser state advanced on accepted items
	csv_in_t next_in;
	result_t got;
	result_t want;

	logic    quiet = 1'b0;
	int      n_fail = 0;
	int      n_items = 0;
	int      n_cfg = 0;
	int      ev_count[5] = '{default: 0};
	ending_t ending;

	csv_record_field_splitter_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// separator limit: register value capped at the hardware maximum
	function automatic logic [CNT_W-1:0] sep_limit(input cfg_t cf);
		if (cf.column_limit > CNT_W'(COLUMN_LIMIT_MAX))
			return CNT_W'(COLUMN_LIMIT_MAX);
		return cf.column_limit;
	endfunction

	// advance the parser by one item and return its result
	function automatic result_t split_step(inout state_t st, input cfg_t cf,
			input logic [BYTE_W-1:0] b, input logic eoi);
		result_t          r;
		logic [POS_W-1:0] pos;
		r = '0;
		pos = st.record_position;
		r.byte_offset = pos[OFF_W-1:0];
		r.field_index = st.separator_count;
		if (st.sticky_error != ERR_NONE) begin
			r.event_res  = EV_ERROR;
			r.error_code = st.sticky_error;
		end else if (st.stream_finished) begin
			r.event_res   = EV_STREAM;
			r.byte_offset = '0;
			r.field_index = '0;
		end else if (eoi) begin
			if (st.in_quotes) begin
				r.event_res     = EV_ERROR;
				r.error_code    = ERR_QUOTED_END;
				st.sticky_error = ERR_QUOTED_END;
			end else begin
				st.stream_finished = 1'b1;
				if (pos != 0) begin
					r.event_res        = EV_RECORD;
					r.content_end      = pos;
					st.record_position = '0;
					st.separator_count = '0;
					st.previous_was_cr = 1'b0;
				end else begin
					r.event_res   = EV_STREAM;
					r.field_index = '0;
				end
			end
		end else if (pos >= MAX_RECORD_BYTES) begin
			r.event_res     = EV_ERROR;
			r.error_code    = ERR_TOO_LONG;
			st.sticky_error = ERR_TOO_LONG;
		end else if (!st.in_quotes && b == cf.separator_char) begin
			if (st.separator_count >= sep_limit(cf)) begin
				r.event_res     = EV_ERROR;
				r.error_code    = ERR_COLUMNS;
				st.sticky_error = ERR_COLUMNS;
			end else begin
				r.event_res        = EV_SEP;
				st.separator_count = st.separator_count + 1'b1;
				st.record_position = pos + 1'b1;
				st.previous_was_cr = 1'b0;
			end
		end else if (!st.in_quotes && b == CH_LF) begin
			r.event_res        = EV_RECORD;
			r.content_end      = (st.previous_was_cr && pos != 0) ? pos - 1'b1 : pos;
			st.record_position = '0;
			st.separator_count = '0;
			st.previous_was_cr = 1'b0;
		end else begin
			// quote enters quotes outside, leaves them inside
			if (b == CH_QUOTE)
				st.in_quotes = ~st.in_quotes;
			st.record_position = pos + 1'b1;
			st.previous_was_cr = (b == CH_CR);
			r.event_res        = EV_PLAIN;
		end
		return r;
	endfunction

	// queue one item and track the state it leaves behind
	task automatic add_item(input logic [BYTE_W-1:0] b, input logic eoi);
		csv_in_t it;
		it.data_byte    = b;
		it.end_of_input = eoi;
		pending_bytes.push_back(it);
		void'(split_step(gen_st, cfg, b, eoi));
		n_items++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], 1'b0);
	endtask

	// queue a byte, bent so that no error arises and records stay short
	task automatic add_safe(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] filler;
		filler = (cfg.separator_char == "a") ? "b" : "a";
		if (!gen_st.in_quotes) begin
			if (b == cfg.separator_char && gen_st.separator_count >= sep_limit(cfg))
				b = filler;
			else if (gen_st.record_position >= 300 && b != cfg.separator_char)
				b = CH_LF;
		end else if (gen_st.record_position >= 300) begin
			b = CH_QUOTE;
		end
		add_item(b, 1'b0);
	endtask

	// one well-formed record with random fields, quoted or plain
	task automatic add_record();
		int nf;
		int len;
		int pick;
		nf = $urandom_range(1, 6);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				add_safe(cfg.separator_char);
			len = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0) begin
				add_safe(CH_QUOTE);
				for (int i = 0; i < len; i++) begin
					pick = $urandom_range(0, 9);
					case (pick)
						0: add_safe(cfg.separator_char);
						1: add_safe(CH_LF);
						2: add_safe(CH_CR);
						3: begin
							add_safe(CH_QUOTE);
							add_safe(CH_QUOTE);
						end
						default: add_safe(BYTE_W'($urandom_range(0, 255)));
					endcase
				end
				add_safe(CH_QUOTE);
			end else begin
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 4) == 0)
						add_safe(BYTE_W'($urandom_range(0, 255)));
					else
						add_safe(BYTE_W'($urandom_range("a", "z")));
				end
			end
		end
		if (gen_st.in_quotes)
			add_safe(CH_QUOTE);
		if ($urandom_range(0, 2) == 0)
			add_safe(CH_CR);
		add_safe(CH_LF);
	endtask

	// mostly records, some bursts of raw bytes
	task automatic add_traffic(input int count);
		int stop_at;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			if ($urandom_range(0, 99) < 85) begin
				add_record();
			end else begin
				repeat ($urandom_range(1, 20))
					add_safe(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// wait until every item is in and every result is out
	task automatic drain();
		while (pending_bytes.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// register write through the configuration port
	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SEPARATOR_CHAR)
			cfg.separator_char = val[BYTE_W-1:0];
		else
			cfg.column_limit = val[CNT_W-1:0];
		n_cfg++;
	endtask

	task automatic set_cfg(input logic [BYTE_W-1:0] sep, input logic [CNT_W-1:0] max_sep);
		drain();
		write_reg(REG_SEPARATOR_CHAR, 32'(sep));
		write_reg(REG_COLUMN_LIMIT, 32'(max_sep));
	endtask

	task automatic close_quotes();
		if (gen_st.in_quotes)
			add_item(CH_QUOTE, 1'b0);
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(split_step(split_st, cfg, s_axis_tdata, s_axis_tuser));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
					next_in = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= next_in.data_byte;
					s_axis_tuser  <= next_in.end_of_input;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			if (n_fail < 50)
				$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
			n_fail++;
		end
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.event_res   = m_axis_tuser;
				got.byte_offset = m_axis_tdata[11:0];
				got.field_index = m_axis_tdata[18:12];
				got.content_end = m_axis_tdata[31:19];
				got.error_code  = m_axis_tdata[33:32];
				if (expected_results.size() == 0) begin
					if (n_fail < 50)
						$display("%0t unexpected result item: event %0d", $time, got.event_res);
					n_fail++;
				end else begin
					want = expected_results.pop_front();
					check_field("event_res", want.event_res, got.event_res);
					check_field("byte_offset", want.byte_offset, got.byte_offset);
					check_field("field_index", want.field_index, got.field_index);
					check_field("content_end", want.content_end, got.content_end);
					check_field("error_code", want.error_code, got.error_code);
					if (want.event_res <= EV_ERROR)
						ev_count[want.event_res]++;
				end
			end
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= 15);
		end
	end

	// stimulus
	initial begin
		cfg.separator_char = SEPARATOR_RESET;
		cfg.column_limit   = MAX_SEP_RESET;
		gen_st   = '0;
		split_st = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: separator, crlf trim, empty records, quoting, byte extremes
		add_text("a,b\015\n");
		add_text("\015\n");
		add_text("\n");
		add_text("\"x,\"\"y\n\"\n");
		add_item(8'h00, 1'b0);
		add_item(8'hff, 1'b0);
		add_item(CH_LF, 1'b0);
		add_traffic(300);

		// top separator byte, single column limit
		set_cfg(8'hff, 7'd1);
		add_item("a", 1'b0);
		add_item(8'hff, 1'b0);
		add_item("b", 1'b0);
		add_item(CH_LF, 1'b0);
		add_traffic(200);

		// zero separator byte, no idling on either side
		set_cfg(8'h00, 7'd2);
		quiet = 1'b1;
		add_traffic(250);
		drain();
		quiet = 1'b0;

		// quote used as separator: never enters quotes
		set_cfg(CH_QUOTE, 7'd64);
		add_text("a\"b\"\"c\n");
		add_traffic(40);

		// lf used as separator: lf never ends a record
		set_cfg(CH_LF, 7'd64);
		add_text("ab\ncd\"x\ny\"z");

		set_cfg(";", 7'd63);
		add_traffic(250);

		// random settings
		repeat (3) begin
			logic [BYTE_W-1:0] sep;
			do sep = BYTE_W'($urandom_range(0, 255)); while (sep == CH_LF || sep == CH_QUOTE);
			set_cfg(sep, CNT_W'($urandom_range(1, 64)));
			add_traffic(200);
		end

		// closing phase: one sticky ending chosen at random
		set_cfg(",", CNT_W'($urandom_range(1, 64)));
		add_traffic(60);
		ending = ending_t'($urandom_range(0, 3));
		close_quotes();
		case (ending)
			END_EOI_EMPTY: begin
				if (gen_st.record_position != 0)
					add_item(CH_LF, 1'b0);
				add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
			end
			END_EOI_RECORD: begin
				if (gen_st.record_position == 0)
					add_item("a", 1'b0);
				add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
			end
			END_EOI_QUOTED: begin
				add_item(CH_QUOTE, 1'b0);
				add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
			end
			default: begin
				while (gen_st.sticky_error == ERR_NONE)
					add_item(",", 1'b0);
			end
		endcase
		// later items keep the sticky outcome
		repeat (6)
			add_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

		drain();
		repeat (4) @(posedge clk);
		$display("run covered %0d items over %0d register writes, ending %s", n_items, n_cfg,
			ending.name());
		$display("results: %0d plain, %0d separators, %0d record ends, %0d stream ends, %0d errors",
			ev_count[EV_PLAIN], ev_count[EV_SEP], ev_count[EV_RECORD], ev_count[EV_STREAM],
			ev_count[EV_ERROR]);
		if (n_fail == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// run time limit
	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
sv/csvs_pkg.sv
sv/csvs_step.sv
sv/csv_record_field_splitter_unit.sv
sv/csvs_checker.sv
tb/sv/tb.sv
